>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the key/value table.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/kvt_pkg.sv
// Package of the key/value table: default sizes, field widths, action codes
// and the memory control group. Depends on nothing.
`default_nettype none

package kvt_pkg;

   // Default sizes of the table.
   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_KEY_BITS    = 32;
   localparam int DEF_VALUE_BITS  = 32;

   // Fixed widths of the channel fields.
   localparam int ACTION_W      = 2;
   localparam int KEY_FIELD_W   = 32;
   localparam int VALUE_FIELD_W = 32;
   localparam int COUNT_FIELD_W = 5;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Control of the entry memories.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } kvt_mem_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/key_value_table_top.sv
// Top level of the key/value table: request sequencer, entry scan and result
// register. Depends on kvt_pkg, kvt_mem and assert_macros.svh.
//
// Usage:
//   A request (req_action, req_key, req_value) transfers when req_valid is
//   high and req_stall is low. Action insert adds or updates a key, lookup
//   reads it, remove deletes it; the unused code changes nothing.
//   Every request gives exactly one result on the rsp_ channel, which
//   transfers when rsp_valid is high and rsp_stall is low.
//   Each request reads all TABLE_DEPTH entries through the single read port
//   of the entry memory, one per cycle, then passes through a write-back
//   state and a finish state. The result is registered, and no new request
//   is taken until the sequencer is back in idle.
//   The result sits in an output register, so the next request is taken
//   while an earlier result is stalled; the sequencer holds its finished
//   result only until that register frees.
//   After reset a clearing pass writes each entry in turn and marks every
//   entry invalid; req_stall stays high during it.
`default_nettype none
`include "assert_macros.svh"

module key_value_table_top
   import kvt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [ACTION_W-1:0]             req_action,
   input  wire logic signed [KEY_FIELD_W-1:0]   req_key,
   input  wire logic signed [VALUE_FIELD_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_hit,
   output logic signed [VALUE_FIELD_W-1:0]      rsp_old_value,
   output logic [COUNT_FIELD_W-1:0]             rsp_entry_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_full_reject
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic                  issue_ff, issue_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  cmp_last_ff, cmp_last_in;
   logic [IDX_W-1:0]      cmp_addr_ff, cmp_addr_in;
   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_ff, free_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   kvt_mem_ctl_type       mem_ctl;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_valid;
   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   logic req_xfer;
   logic rsp_xfer;
   logic rsp_load;
   logic hit_eff;
   logic reject;

   kvt_mem #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS),
      .IDX_W       (IDX_W)
   ) u_kvt_mem (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_valid (wr_valid),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd_addr  (addr_ff),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   // Handshake terms.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   // The unused action never reports a hit; a refused insert is a miss with no free slot.
   assign hit_eff = hit_ff && (action_ff != ACT_UNUSED);
   assign reject  = (action_ff == ACT_INSERT) && !hit_ff && !free_found_ff;

   // Sequencer, scan compare and write-back decisions.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_last_in   = (addr_ff == LAST_IDX);
      cmp_addr_in   = addr_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      action_in     = action_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      wr_addr       = addr_ff;
      wr_valid      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               action_in     = req_action;
               key_in        = KEY_BITS'($unsigned(req_key));
               value_in      = VALUE_BITS'($unsigned(req_value));
               addr_in       = '0;
               issue_in      = 1'b1;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; the compare follows in the next cycle.
            if (issue_ff) begin
               mem_ctl.rd_en = 1'b1;
               cmp_valid_in  = 1'b1;
               if (addr_ff == LAST_IDX) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (cmp_valid_ff) begin
               if (rd_valid && (rd_key == key_ff)) begin
                  hit_in  = 1'b1;
                  slot_in = cmp_addr_ff;
                  prev_in = rd_value;
               end else if (!rd_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = cmp_addr_ff;
               end
               if (cmp_last_ff) begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            unique case (action_ff)
               ACT_INSERT: begin
                  if (hit_ff) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = slot_ff;
                     wr_valid      = 1'b1;
                  end else if (free_found_ff) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = free_ff;
                     wr_valid      = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
               ACT_REMOVE: begin
                  if (hit_ff) begin
                     mem_ctl.wr_en = 1'b1;
                     wr_addr       = slot_ff;
                     wr_valid      = 1'b0;
                     count_in      = count_ff - 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: freed by a transfer, loaded when the sequencer finishes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         issue_ff      <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         issue_ff      <= issue_in;
         cmp_valid_ff  <= cmp_valid_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers of the request and of the scan.
   always_ff @(posedge clock) begin
      cmp_last_ff <= cmp_last_in;
      cmp_addr_ff <= cmp_addr_in;
      slot_ff     <= slot_in;
      prev_ff     <= prev_in;
      free_ff     <= free_in;
      action_ff   <= action_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
   end

   // Result payload, loaded once per request.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit         <= hit_eff;
         rsp_old_value   <= hit_eff ? VALUE_FIELD_W'(prev_ff) : '0;
         rsp_entry_count <= COUNT_FIELD_W'(count_ff);
         rsp_is_empty    <= (count_ff == '0);
         rsp_full_reject <= reject;
      end
   end

   // Checks on the sequencer and the entry count.
   `ASSERT_SAME(a_count_bound, 1'b1, count_ff <= FULL_CNT, "entry count above table depth")
   `ASSERT_SAME(a_no_write_in_scan, state_ff == ST_SCAN, !mem_ctl.wr_en,
                "memory write during a scan")
   `ASSERT_SAME(a_no_free_means_full, (state_ff == ST_WRITE) && !free_found_ff,
                count_ff == FULL_CNT, "no free entry found while the count says not full")
   `ASSERT_NEXT(a_req_starts_scan, req_xfer, state_ff == ST_SCAN,
                "accepted request did not start a scan")
   `ASSERT_SAME(a_reject_is_miss, rsp_valid_ff && rsp_full_reject,
                !rsp_hit && (rsp_entry_count == COUNT_FIELD_W'(FULL_CNT)),
                "refused insert reported a hit or a table that was not full")

endmodule

`default_nettype wire

>>> hw/rtl/kvt_mem.sv
// Entry store of the key/value table: valid, key and value arrays with one
// write port and one registered read port. Depends on kvt_pkg.
`default_nettype none

module kvt_mem
   import kvt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS,
   parameter int VALUE_BITS  = DEF_VALUE_BITS,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire kvt_mem_ctl_type       mem_ctl,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire logic                  wr_valid,
   input  wire logic [KEY_BITS-1:0]   wr_key,
   input  wire logic [VALUE_BITS-1:0] wr_value,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output logic                       rd_valid,
   output logic [KEY_BITS-1:0]        rd_key,
   output logic [VALUE_BITS-1:0]      rd_value
);

   logic                  valid_mem_ff [TABLE_DEPTH];
   logic [KEY_BITS-1:0]   key_mem_ff   [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem_ff [TABLE_DEPTH];

   // Write port: valid mark, key and value of one entry in one transfer.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         valid_mem_ff[wr_addr] <= wr_valid;
         key_mem_ff[wr_addr]   <= wr_key;
         value_mem_ff[wr_addr] <= wr_value;
      end
   end

   // Registered read port, loaded when rd_en is high.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_valid <= valid_mem_ff[rd_addr];
         rd_key   <= key_mem_ff[rd_addr];
         rd_value <= value_mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
